FILE: rtl/core/dbl_pkg.sv
// dbl_pkg: shared types and constants of the dual button debouncer
// holds register indexes, reset values, beat layouts and the lane status struct
// no dependencies
package dbl_pkg;

  localparam int unsigned TS_W       = 32;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned NUM_LANES  = 2;

  // lane order inside one sample
  localparam int unsigned LANE_UP   = 0;
  localparam int unsigned LANE_DOWN = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_PIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UP_EN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_EN    = 3'd4;

  // register reset values
  localparam logic [MS_W-1:0] RST_DEBOUNCE   = 16'd50;
  localparam logic [MS_W-1:0] RST_LONG_PRESS = 16'd3000;

  // input beat layout
  localparam int unsigned IN_NOW_LSB  = 0;
  localparam int unsigned IN_UP_BIT   = 32;
  localparam int unsigned IN_DOWN_BIT = 33;

  // output beat layout
  localparam int unsigned OUT_JOG_UP_BIT   = 0;
  localparam int unsigned OUT_JOG_DOWN_BIT = 1;
  localparam int unsigned OUT_PORTAL_BIT   = 2;
  localparam int unsigned OUT_UP_HELD_BIT  = 3;
  localparam int unsigned OUT_DOWN_HELD_BIT = 4;

  // what one lane found for the current sample
  typedef struct packed {
    logic jog;        // accepted press
    logic level_nxt;  // debounced level after this sample
    logic long_hit;   // long press reached in this sample
  } lane_status_t;

endpackage

FILE: rtl/core/dbl_lane.sv
// dbl_lane: debounce and long-press core for one button
// keeps the button state and updates it on each accepted sample
// depends on dbl_pkg
module dbl_lane (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fire,
  input  logic                      enable,
  input  logic                      invert_pin,
  input  logic [dbl_pkg::MS_W-1:0]  debounce_ms,
  input  logic [dbl_pkg::MS_W-1:0]  long_press_ms,
  input  logic [dbl_pkg::TS_W-1:0]  now_ms,
  input  logic                      raw_level,
  output logic                      level_q,
  output dbl_pkg::lane_status_t     status
);
  import dbl_pkg::*;

  logic            stable_r, stable_nxt;
  logic [TS_W-1:0] change_time_r, change_time_nxt;
  logic [TS_W-1:0] press_time_r, press_time_nxt;
  logic            long_done_r, long_done_nxt;

  logic            pressed;
  logic [TS_W-1:0] since_change;
  logic [TS_W-1:0] since_press;
  logic            accept_change;
  logic            accept_press;
  logic            long_hit;

  always_comb begin
    pressed       = invert_pin ? ~raw_level : raw_level;
    since_change  = now_ms - change_time_r;
    since_press   = now_ms - press_time_r;
    accept_change = enable && (pressed != stable_r) &&
                    (since_change > {{(TS_W-MS_W){1'b0}}, debounce_ms});
    accept_press  = accept_change && pressed;
    // a fresh press has zero age, so it can never be long in the same sample
    long_hit      = enable && pressed && !long_done_r && !accept_press &&
                    (since_press > {{(TS_W-MS_W){1'b0}}, long_press_ms});

    stable_nxt      = accept_change ? pressed : stable_r;
    change_time_nxt = accept_change ? now_ms : change_time_r;
    press_time_nxt  = accept_press ? now_ms : press_time_r;
    long_done_nxt   = accept_press ? 1'b0 : (long_hit ? 1'b1 : long_done_r);

    status.jog       = accept_press;
    status.level_nxt = stable_nxt;
    status.long_hit  = long_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r      <= 1'b0;
      change_time_r <= '0;
      press_time_r  <= '0;
      long_done_r   <= 1'b0;
    end else if (fire) begin
      stable_r      <= stable_nxt;
      change_time_r <= change_time_nxt;
      press_time_r  <= press_time_nxt;
      long_done_r   <= long_done_nxt;
    end
  end

  assign level_q = stable_r;

endmodule

FILE: rtl/core/dbl_merge.sv
// dbl_merge: combines the lane results into one result beat
// resolves the both-pressed check in up-then-down order and registers the beat
// depends on dbl_pkg
module dbl_merge (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  fire,
  input  dbl_pkg::lane_status_t                 up_status,
  input  dbl_pkg::lane_status_t                 down_status,
  input  logic                                  down_level_q,
  input  logic                                  out_tready,
  output logic                                  out_tvalid,
  output logic [dbl_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                  slot_free
);
  import dbl_pkg::*;

  logic                  valid_r, valid_nxt;
  logic [OUT_DATA_W-1:0] data_r, data_nxt;
  logic                  portal;

  always_comb begin
    // up check sees the old down level, down check sees both new levels
    portal = (up_status.long_hit && up_status.level_nxt && down_level_q) ||
             (down_status.long_hit && up_status.level_nxt && down_status.level_nxt);

    data_nxt                    = '0;
    data_nxt[OUT_JOG_UP_BIT]    = up_status.jog;
    data_nxt[OUT_JOG_DOWN_BIT]  = down_status.jog;
    data_nxt[OUT_PORTAL_BIT]    = portal;
    data_nxt[OUT_UP_HELD_BIT]   = up_status.level_nxt;
    data_nxt[OUT_DOWN_HELD_BIT] = down_status.level_nxt;

    slot_free = !valid_r || out_tready;
    valid_nxt = fire ? 1'b1 : (out_tready ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      data_r <= data_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

FILE: rtl/core/dual_button_debounce_longpress.sv
// dual_button_debounce_longpress: two-button debouncer with long-press detect
// result beat: registered, presented in the cycle after its sample beat is accepted
// throughput: one sample per cycle unless out_tready stalls; lane state updates on each accepted sample
// reset: rst_n synchronous active low, clears button state and restores registers
// depends on dbl_pkg, dbl_lane, dbl_merge
module dual_button_debounce_longpress (
  input  logic                              clk,
  input  logic                              rst_n,
  // sample stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [dbl_pkg::IN_DATA_W-1:0]     in_tdata,   // now_ms[31:0], up_level, down_level
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [dbl_pkg::OUT_DATA_W-1:0]    out_tdata,  // jog_up, jog_down, portal_request,
                                                        // up_held, down_held
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dbl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dbl_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dbl_pkg::*;

  // configuration registers
  logic [MS_W-1:0] debounce_r;
  logic [MS_W-1:0] long_press_r;
  logic            invert_pin_r;
  logic            up_en_r;
  logic            down_en_r;

  logic            cfg_fire;
  logic            in_fire;
  logic            slot_free;

  logic [TS_W-1:0] now_ms;
  logic            up_level;
  logic            down_level;

  lane_status_t    up_status;
  lane_status_t    down_status;
  logic            up_level_q;
  logic            down_level_q;

  // registers are always writable; the user must write them only while the block is idle, the block does not enforce it
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= RST_DEBOUNCE;
      long_press_r <= RST_LONG_PRESS;
      invert_pin_r <= 1'b1;
      up_en_r      <= 1'b1;
      down_en_r    <= 1'b1;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_DEBOUNCE:   debounce_r   <= cfg_data;
        REG_LONG_PRESS: long_press_r <= cfg_data;
        REG_INVERT_PIN: invert_pin_r <= cfg_data[0];
        REG_UP_EN:      up_en_r      <= cfg_data[0];
        REG_DOWN_EN:    down_en_r    <= cfg_data[0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // unpack the sample beat
  assign now_ms     = in_tdata[IN_NOW_LSB +: TS_W];
  assign up_level   = in_tdata[IN_UP_BIT];
  assign down_level = in_tdata[IN_DOWN_BIT];

  // a new sample enters whenever the output register is empty or draining
  assign in_tready = slot_free;
  assign in_fire   = in_tvalid && in_tready;

  // one lane per button, both evaluated on the same sample
  dbl_lane u_lane_up (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (in_fire),
    .enable        (up_en_r),
    .invert_pin    (invert_pin_r),
    .debounce_ms   (debounce_r),
    .long_press_ms (long_press_r),
    .now_ms        (now_ms),
    .raw_level     (up_level),
    .level_q       (up_level_q),
    .status        (up_status)
  );

  dbl_lane u_lane_down (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (in_fire),
    .enable        (down_en_r),
    .invert_pin    (invert_pin_r),
    .debounce_ms   (debounce_r),
    .long_press_ms (long_press_r),
    .now_ms        (now_ms),
    .raw_level     (down_level),
    .level_q       (down_level_q),
    .status        (down_status)
  );

  // merge lane findings into the registered result beat
  dbl_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (in_fire),
    .up_status    (up_status),
    .down_status  (down_status),
    .down_level_q (down_level_q),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_tdata    (out_tdata),
    .slot_free    (slot_free)
  );

  // every accepted sample produces a result beat on the next cycle
  a_sample_gives_result: assert property (
    @(posedge clk) disable iff (!rst_n) in_fire |=> out_tvalid
  ) else $error("accepted sample produced no result beat");

  // a disabled up button keeps its debounced level
  a_up_disabled_frozen: assert property (
    @(posedge clk) disable iff (!rst_n) (in_fire && !up_en_r) |=> $stable(up_level_q)
  ) else $error("disabled up button changed level");

  // a jog pulse always comes with the button held
  a_jog_implies_held: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[OUT_JOG_UP_BIT] || out_tdata[OUT_UP_HELD_BIT]) &&
                   (!out_tdata[OUT_JOG_DOWN_BIT] || out_tdata[OUT_DOWN_HELD_BIT])
  ) else $error("jog pulse without held level");

endmodule
